// ----- rtl/core/x86md_pkg.sv -----
// ----------------------------------------------------------------------------
// x86md_pkg: shared types and constants of the multiply/divide unit
// Holds the operation codes, the cell count and the record that moves
// from one cell of the row to the next.
// ----------------------------------------------------------------------------
package x86md_pkg;

  localparam int unsigned NumCells = 16;
  localparam int unsigned StepW    = 5;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_IMUL = 2'd1,
    OP_DIV  = 2'd2,
    OP_IDIV = 2'd3
  } op_t;

  // One in-flight item as it travels along the row.
  typedef struct packed {
    logic        vld;
    logic        is_div;
    logic        sgn;
    logic        word;
    logic [15:0] ax;
    logic [15:0] dx;
    logic [31:0] prod;
    logic [31:0] mcand;
    logic [15:0] mplier;
    logic [31:0] rem;
    logic [15:0] quo;
    logic [15:0] dvs;
    logic        neg_q;
    logic        neg_r;
    logic        zero_dvs;
  } md_beat_t;

endpackage

// ----- rtl/core/x86md_cell.sv -----
// ----------------------------------------------------------------------------
// x86md_cell: one step of the multiply/divide row
// Retires one multiplier bit by shift-and-add or one quotient bit by
// restoring subtraction, then registers the record for the next cell.
// ----------------------------------------------------------------------------
module x86md_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [x86md_pkg::StepW-1:0] step,
  input  x86md_pkg::md_beat_t        beat_i,
  output x86md_pkg::md_beat_t        beat_o
);

  x86md_pkg::md_beat_t beat_r;
  x86md_pkg::md_beat_t beat_nxt;
  logic [31:0]         shifted;
  logic [32:0]         diff;
  logic [4:0]          bit_idx;

  // Step k handles multiplier bit k, or quotient bit (15 - k).
  always_comb begin
    beat_nxt = beat_i;
    bit_idx  = 5'd15 - step;
    shifted  = beat_i.mcand << step;
    diff     = 33'd0;
    if (beat_i.is_div) begin
      diff = {1'b0, beat_i.rem} - ({17'd0, beat_i.dvs} << bit_idx);
      if (!diff[32]) begin
        beat_nxt.rem = diff[31:0];
        beat_nxt.quo[bit_idx[3:0]] = 1'b1;
      end
    end else if (beat_i.mplier[step[3:0]]) begin
      beat_nxt.prod = beat_i.prod + shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_o = beat_r;

endmodule

// ----- rtl/core/x86_multiply_divide_unit.sv -----
// ----------------------------------------------------------------------------
// x86_multiply_divide_unit: 8086 MUL, IMUL, DIV and IDIV at byte or word width
// Pipeline: an input beat reaches the result through the entry stage, sixteen
// cells and the result stage. Throughput: one beat per cycle; the whole row
// advances together and stalls only while the result beat waits.
// Reset: synchronous active-low rst_n clears every valid bit; no payload reset.
// ----------------------------------------------------------------------------
module x86_multiply_divide_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic        in_word_size,
  input  logic [15:0] in_operand,
  input  logic [15:0] in_acc_low_in,
  input  logic [15:0] in_acc_high_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_acc_low_out,
  output logic [15:0] out_acc_high_out,
  output logic        out_carry_overflow,
  output logic        out_divide_error
);

  localparam int unsigned N = x86md_pkg::NumCells;

  x86md_pkg::md_beat_t row [N+1];
  x86md_pkg::md_beat_t entry_r, entry_nxt;
  logic                adv;
  x86md_pkg::op_t      op;

  logic        o_vld_r;
  logic [15:0] o_ax_r, o_dx_r, o_ax_nxt, o_dx_nxt;
  logic        o_cf_r, o_err_r, o_cf_nxt, o_err_nxt;

  assign adv      = !o_vld_r || out_ready;
  assign in_ready = adv;
  assign op       = x86md_pkg::op_t'(in_mode);

  // Operand preparation: magnitudes for division, a 32-bit multiplicand (sign-extended for IMUL) for multiply.
  always_comb begin
    logic        sgn;
    logic [31:0] num, numa;
    logic [15:0] den, dena;
    logic        nneg, dneg;
    sgn  = (op == x86md_pkg::OP_IMUL) || (op == x86md_pkg::OP_IDIV);
    num  = in_word_size ? {in_acc_high_in, in_acc_low_in} : {16'd0, in_acc_low_in};
    den  = in_word_size ? in_operand : {8'd0, in_operand[7:0]};
    nneg = sgn && (in_word_size ? num[31] : num[15]);
    dneg = sgn && (in_word_size ? den[15] : den[7]);
    numa = nneg ? (in_word_size ? (32'd0 - num) : {16'd0, 16'd0 - num[15:0]}) : num;
    dena = dneg ? (in_word_size ? (16'd0 - den) : {8'd0, 8'd0 - den[7:0]}) : den;
    entry_nxt          = '0;
    entry_nxt.vld      = in_valid;
    entry_nxt.is_div   = in_mode[1];
    entry_nxt.sgn      = sgn;
    entry_nxt.word     = in_word_size;
    entry_nxt.ax       = in_acc_low_in;
    entry_nxt.dx       = in_acc_high_in;
    entry_nxt.rem      = numa;
    entry_nxt.dvs      = dena;
    entry_nxt.neg_q    = nneg ^ dneg;
    entry_nxt.neg_r    = nneg;
    entry_nxt.zero_dvs = (den == 16'd0);
    if (in_word_size) begin
      entry_nxt.mcand  = sgn ? {{16{in_acc_low_in[15]}}, in_acc_low_in}
                             : {16'd0, in_acc_low_in};
      entry_nxt.mplier = in_operand;
    end else begin
      entry_nxt.mcand  = sgn ? {{24{in_acc_low_in[7]}}, in_acc_low_in[7:0]}
                             : {24'd0, in_acc_low_in[7:0]};
      entry_nxt.mplier = {8'd0, in_operand[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.vld <= 1'b0;
    end else if (adv) begin
      entry_r <= entry_nxt;
    end
  end

  assign row[0] = entry_r;

  for (genvar k = 0; k < N; k++) begin : g_cell
    x86md_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .step   (x86md_pkg::StepW'(k)),
      .beat_i (row[k]),
      .beat_o (row[k+1])
    );
  end

  // Finish: signed multiply correction, sign fix-up, range checks.
  always_comb begin
    x86md_pkg::md_beat_t b;
    logic [31:0] p;
    logic [15:0] q, r;
    logic        ovf;
    logic        big;
    b = row[N];
    p = b.prod;
    // Signed multiplier with top bit set: subtract multiplicand at twice that bit's weight.
    if (b.sgn && !b.is_div) begin
      if (b.word && b.mplier[15]) p = p - (b.mcand << 16);
      if (!b.word && b.mplier[7]) p = p - (b.mcand << 8);
    end
    q = b.neg_q ? (16'd0 - b.quo) : b.quo;
    r = b.neg_r ? (16'd0 - b.rem[15:0]) : b.rem[15:0];
    // A remainder left at or above the divisor means the quotient needs more
    // than sixteen bits.
    big = (b.rem >= {16'd0, b.dvs});
    if (b.sgn) begin
      ovf = b.word ? (big || (b.neg_q ? (b.quo > 16'h8000) : b.quo[15]))
                   : ((b.quo[15:8] != 8'd0) || (b.neg_q ? (b.quo[7:0] > 8'h80)
                                                         : b.quo[7]));
    end else begin
      ovf = b.word ? big : (b.quo[15:8] != 8'd0);
    end
    o_ax_nxt  = b.ax;
    o_dx_nxt  = b.dx;
    o_cf_nxt  = 1'b0;
    o_err_nxt = 1'b0;
    if (!b.is_div) begin
      if (b.word) begin
        o_ax_nxt = p[15:0];
        o_dx_nxt = p[31:16];
        o_cf_nxt = b.sgn ? (p[31:16] != {16{p[15]}}) : (p[31:16] != 16'd0);
      end else begin
        o_ax_nxt = p[15:0];
        o_cf_nxt = b.sgn ? (p[15:8] != {8{p[7]}}) : (p[15:8] != 8'd0);
      end
    end else if (b.zero_dvs || ovf) begin
      o_err_nxt = 1'b1;
    end else if (b.word) begin
      o_ax_nxt = q;
      o_dx_nxt = r;
    end else begin
      o_ax_nxt = {r[7:0], q[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= row[N].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_ax_r  <= o_ax_nxt;
      o_dx_r  <= o_dx_nxt;
      o_cf_r  <= o_cf_nxt;
      o_err_r <= o_err_nxt;
    end
  end

  assign out_valid          = o_vld_r;
  assign out_acc_low_out    = o_ax_r;
  assign out_acc_high_out   = o_dx_r;
  assign out_carry_overflow = o_cf_r;
  assign out_divide_error   = o_err_r;

  a_ready_follows_out : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the result stage");
  a_err_no_cf : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_divide_error && out_carry_overflow))
    else $error("divide error and carry both set");
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_acc_low_out) && out_valid)
    else $error("result changed while stalled");

endmodule
